### rtl/core/tmcs_pkg.sv
// ----------------------------------------------------------------------------
// tmcs_pkg
// Shared types, codes and sizes of the three-address processor core.
// ----------------------------------------------------------------------------
package tmcs_pkg;

    // Memory and register file sizes.
    localparam int IMEM_DEPTH = 1024;
    localparam int DMEM_DEPTH = 1024;
    localparam int REG_COUNT  = 8;
    localparam int PC_INDEX   = 7;

    localparam int IA_W      = $clog2(IMEM_DEPTH);
    localparam int DA_W      = $clog2(DMEM_DEPTH);
    localparam int RA_W      = $clog2(REG_COUNT);
    localparam int MAX_DEPTH = (IMEM_DEPTH > DMEM_DEPTH) ? IMEM_DEPTH : DMEM_DEPTH;
    localparam int CNT_W     = $clog2(MAX_DEPTH);

    // Command codes of an input beat.
    localparam logic [1:0] CMD_STEP  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    // Opcodes.
    localparam logic [4:0] OP_HALT = 5'd0;
    localparam logic [4:0] OP_IN   = 5'd1;
    localparam logic [4:0] OP_OUT  = 5'd2;
    localparam logic [4:0] OP_ADD  = 5'd3;
    localparam logic [4:0] OP_SUB  = 5'd4;
    localparam logic [4:0] OP_MUL  = 5'd5;
    localparam logic [4:0] OP_DIV  = 5'd6;
    localparam logic [4:0] OP_LD   = 5'd7;
    localparam logic [4:0] OP_ST   = 5'd8;
    localparam logic [4:0] OP_LDA  = 5'd9;
    localparam logic [4:0] OP_LDC  = 5'd10;
    localparam logic [4:0] OP_JLT  = 5'd11;
    localparam logic [4:0] OP_JLE  = 5'd12;
    localparam logic [4:0] OP_JGT  = 5'd13;
    localparam logic [4:0] OP_JGE  = 5'd14;
    localparam logic [4:0] OP_JEQ  = 5'd15;
    localparam logic [4:0] OP_JNE  = 5'd16;

    // Status codes of a result beat.
    localparam logic [2:0] ST_OK     = 3'd0;
    localparam logic [2:0] ST_HALT   = 3'd1;
    localparam logic [2:0] ST_IFAULT = 3'd2;
    localparam logic [2:0] ST_DFAULT = 3'd3;
    localparam logic [2:0] ST_DIVZ   = 3'd4;

    // One instruction word as held in the instruction store.
    typedef struct packed {
        logic [4:0]  op;
        logic [2:0]  ra;
        logic [15:0] disp;
        logic [2:0]  rb;
    } instr_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic disp;
        logic fetch;
        logic rd_t;
        logic rd_s;
        logic rd_r;
        logic exec;
        logic div_start;
        logic div_cap;
        logic ld_cap;
        logic wb;
        logic sweep_init;
        logic sweep_clear;
        logic load_res;
    } ctl_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [1:0] cmd;
        logic       pc_fault;
        logic [4:0] op;
        logic       div_zero;
        logic       addr_fault;
        logic       div_done;
        logic       init_last;
        logic       clear_last;
        logic       out_free;
    } stat_t;

endpackage

### rtl/core/tiny_machine_cpu_step_top.sv
// ----------------------------------------------------------------------------
// tiny_machine_cpu_step_top
// Small three-address processor core that loads, clears or steps per beat.
// ----------------------------------------------------------------------------
// Each input beat yields one result beat. After reset the core sweeps both
// stores over max(IMEM_DEPTH, DMEM_DEPTH) addresses and takes no beat until
// done. A write beat and an unused command go from dispatch straight to the
// result state. A clear beat sweeps the data store one word a cycle. A step
// reads its operands through the single register file read port (three reads
// per instruction), passes a load wait or a write-back state where it needs
// one and waits on the bit-serial divider for a divide. A step whose pc lies
// outside the instruction store goes straight to the result state. A stalled
// result beat holds the core until taken. One beat is in flight at a time.
module tiny_machine_cpu_step_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         cmd,
    input  logic [9:0]         instr_addr,
    input  logic [4:0]         instr_op,
    input  logic [2:0]         instr_arg1,
    input  logic signed [15:0] instr_arg2,
    input  logic [2:0]         instr_arg3,
    input  logic signed [31:0] in_value,
    output logic               res_valid,
    input  logic               res_ready,
    output logic [2:0]         status,
    output logic               out_valid,
    output logic signed [31:0] out_value,
    output logic signed [31:0] next_pc
);
    import tmcs_pkg::*;

    ctl_t  ctl;
    stat_t stat;

    tmcs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .ctl      (ctl)
    );

    tmcs_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .stat       (stat),
        .in_valid   (in_valid),
        .cmd        (cmd),
        .instr_addr (instr_addr),
        .instr_op   (instr_op),
        .instr_arg1 (instr_arg1),
        .instr_arg2 (instr_arg2),
        .instr_arg3 (instr_arg3),
        .in_value   (in_value),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .status     (status),
        .out_valid  (out_valid),
        .out_value  (out_value),
        .next_pc    (next_pc)
    );

endmodule

### rtl/core/tmcs_ram.sv
// ----------------------------------------------------------------------------
// tmcs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tmcs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/core/tmcs_div.sv
// ----------------------------------------------------------------------------
// tmcs_div
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
// ----------------------------------------------------------------------------
module tmcs_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [31:0] divisor,
    output logic        done,
    output logic [31:0] quotient
);

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [31:0] quo_reg, quo_next;
    logic [31:0] rem_reg, rem_next;
    logic [31:0] den_reg, den_next;
    logic        neg_reg, neg_next;
    logic [32:0] part;
    logic [32:0] trial;

    // One restoring step per cycle on the magnitudes.
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        neg_next  = neg_reg;
        part      = {rem_reg, quo_reg[31]};
        trial     = part - {1'b0, den_reg};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = 5'd0;
            quo_next  = dividend[31] ? (32'd0 - dividend) : dividend;
            den_next  = divisor[31] ? (32'd0 - divisor) : divisor;
            rem_next  = 32'd0;
            neg_next  = dividend[31] ^ divisor[31];
        end
        else if (busy_reg)
        begin
            if (part >= {1'b0, den_reg})
            begin
                rem_next = trial[31:0];
                quo_next = {quo_reg[30:0], 1'b1};
            end
            else
            begin
                rem_next = part[31:0];
                quo_next = {quo_reg[30:0], 1'b0};
            end
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd31)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 5'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Operand registers.
    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
        neg_reg <= neg_next;
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? (32'd0 - quo_reg) : quo_reg;

endmodule

### rtl/core/tmcs_ctrl.sv
// ----------------------------------------------------------------------------
// tmcs_ctrl
// Sequencer of the core: init sweep, command dispatch and instruction phases.
// ----------------------------------------------------------------------------
module tmcs_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  tmcs_pkg::stat_t stat,
    output tmcs_pkg::ctl_t  ctl
);
    import tmcs_pkg::*;

    typedef enum logic [12:0] {
        S_INIT  = 13'b0000000000001,
        S_IDLE  = 13'b0000000000010,
        S_DISP  = 13'b0000000000100,
        S_FETCH = 13'b0000000001000,
        S_RDT   = 13'b0000000010000,
        S_RDS   = 13'b0000000100000,
        S_RDR   = 13'b0000001000000,
        S_EXEC  = 13'b0000010000000,
        S_DIV   = 13'b0000100000000,
        S_LDW   = 13'b0001000000000,
        S_WB    = 13'b0010000000000,
        S_CLEAR = 13'b0100000000000,
        S_DONE  = 13'b1000000000000
    } state_t;

    state_t state_reg, state_next;

    // Next state and command decode.
    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_INIT:
            begin
                ctl.sweep_init = 1'b1;
                if (stat.init_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_ready   = 1'b1;
                ctl.accept = 1'b1;
                if (in_valid)
                begin
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                ctl.disp = 1'b1;
                case (stat.cmd)
                    CMD_STEP:  state_next = stat.pc_fault ? S_DONE : S_FETCH;
                    CMD_CLEAR: state_next = S_CLEAR;
                    default:   state_next = S_DONE;
                endcase
            end
            S_FETCH:
            begin
                ctl.fetch  = 1'b1;
                state_next = S_RDT;
            end
            S_RDT:
            begin
                ctl.rd_t   = 1'b1;
                state_next = S_RDS;
            end
            S_RDS:
            begin
                ctl.rd_s   = 1'b1;
                state_next = S_RDR;
            end
            S_RDR:
            begin
                ctl.rd_r   = 1'b1;
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                ctl.exec = 1'b1;
                if (stat.op == OP_DIV && !stat.div_zero)
                begin
                    ctl.div_start = 1'b1;
                    state_next    = S_DIV;
                end
                else if (stat.op == OP_LD && !stat.addr_fault)
                begin
                    state_next = S_LDW;
                end
                else if (stat.op inside {OP_IN, OP_ADD, OP_SUB, OP_MUL, OP_LDA, OP_LDC})
                begin
                    state_next = S_WB;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_DIV:
            begin
                if (stat.div_done)
                begin
                    ctl.div_cap = 1'b1;
                    state_next  = S_WB;
                end
            end
            S_LDW:
            begin
                ctl.ld_cap = 1'b1;
                state_next = S_WB;
            end
            S_WB:
            begin
                ctl.wb     = 1'b1;
                state_next = S_DONE;
            end
            S_CLEAR:
            begin
                ctl.sweep_clear = 1'b1;
                if (stat.clear_last)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (stat.out_free)
                begin
                    ctl.load_res = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

### rtl/core/tmcs_dp.sv
// ----------------------------------------------------------------------------
// tmcs_dp
// Datapath of the core: register file, stores, ALU, divider and result stage.
// ----------------------------------------------------------------------------
module tmcs_dp (
    input  logic                clk,
    input  logic                rst_n,
    input  tmcs_pkg::ctl_t      ctl,
    output tmcs_pkg::stat_t     stat,
    input  logic                in_valid,
    input  logic [1:0]          cmd,
    input  logic [9:0]          instr_addr,
    input  logic [4:0]          instr_op,
    input  logic [2:0]          instr_arg1,
    input  logic signed [15:0]  instr_arg2,
    input  logic [2:0]          instr_arg3,
    input  logic signed [31:0]  in_value,
    output logic                res_valid,
    input  logic                res_ready,
    output logic [2:0]          status,
    output logic                out_valid,
    output logic signed [31:0]  out_value,
    output logic signed [31:0]  next_pc
);
    import tmcs_pkg::*;

    // Latched input beat.
    logic [1:0]  cmd_reg;
    logic [9:0]  iaddr_reg;
    instr_t      iword_reg;
    logic [31:0] inval_reg;

    // Machine state and working registers.
    logic [31:0]          pc_reg, pc_next;
    logic [REG_COUNT-1:0] vld_reg, vld_next;
    instr_t               ir_reg;
    logic [31:0]          t_reg, s_reg, r_reg;
    logic [31:0]          res_reg, res_next;
    logic [2:0]           st_reg, st_next;
    logic                 ov_reg, ov_next;
    logic [31:0]          oval_reg, oval_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;

    // Result stage.
    logic        rv_reg;
    logic [2:0]  ost_reg;
    logic        oov_reg;
    logic [31:0] ooval_reg;
    logic [31:0] onpc_reg;

    // Memory ports.
    instr_t           im_rdata, im_wdata;
    logic             im_we;
    logic [IA_W-1:0]  im_waddr;
    logic [31:0]      dm_rdata, dm_wdata;
    logic             dm_we;
    logic [DA_W-1:0]  dm_waddr;
    logic [31:0]      rf_rdata, rf_wdata, rf_val;
    logic             rf_we;
    logic [RA_W-1:0]  rf_raddr, rf_raddr_reg, rf_waddr;

    // Divider.
    logic        div_done;
    logic [31:0] div_q;

    logic [31:0] disp_ext, maddr;
    logic        neg, zero, take;
    logic        dfault, dzero;

    tmcs_ram #(.WIDTH($bits(instr_t)), .DEPTH(IMEM_DEPTH)) u_imem (
        .clk   (clk),
        .we    (im_we),
        .waddr (im_waddr),
        .wdata (im_wdata),
        .raddr (IA_W'(pc_reg)),
        .rdata (im_rdata)
    );

    tmcs_ram #(.WIDTH(32), .DEPTH(DMEM_DEPTH)) u_dmem (
        .clk   (clk),
        .we    (dm_we),
        .waddr (dm_waddr),
        .wdata (dm_wdata),
        .raddr (DA_W'(maddr)),
        .rdata (dm_rdata)
    );

    tmcs_ram #(.WIDTH(32), .DEPTH(REG_COUNT)) u_rf (
        .clk   (clk),
        .we    (rf_we),
        .waddr (rf_waddr),
        .wdata (rf_wdata),
        .raddr (rf_raddr),
        .rdata (rf_rdata)
    );

    tmcs_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (ctl.div_start),
        .dividend (s_reg),
        .divisor  (t_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    // Register read: the pc index reads the pc, an unwritten entry reads zero.
    always_comb
    begin
        rf_raddr = RA_W'(ir_reg.ra);
        if (ctl.fetch)
        begin
            rf_raddr = RA_W'(im_rdata.rb);
        end
        else if (ctl.rd_t)
        begin
            rf_raddr = RA_W'(ir_reg.disp[2:0]);
        end
        if (32'(rf_raddr_reg) == PC_INDEX)
        begin
            rf_val = pc_reg;
        end
        else
        begin
            rf_val = vld_reg[rf_raddr_reg] ? rf_rdata : 32'd0;
        end
    end

    // Effective address and branch tests.
    assign disp_ext = {{16{ir_reg.disp[15]}}, ir_reg.disp};
    assign maddr    = disp_ext + t_reg;
    assign neg      = r_reg[31];
    assign zero     = (r_reg == 32'd0);
    assign dfault   = (maddr >= 32'(DMEM_DEPTH));
    assign dzero    = (t_reg == 32'd0);

    always_comb
    begin
        case (ir_reg.op)
            OP_JLT:  take = neg;
            OP_JLE:  take = neg || zero;
            OP_JGT:  take = !neg && !zero;
            OP_JGE:  take = !neg;
            OP_JEQ:  take = zero;
            OP_JNE:  take = !zero;
            default: take = 1'b0;
        endcase
    end

    // Main datapath operations per phase.
    always_comb
    begin
        pc_next   = pc_reg;
        vld_next  = vld_reg;
        res_next  = res_reg;
        st_next   = st_reg;
        ov_next   = ov_reg;
        oval_next = oval_reg;
        cnt_next  = '0;
        im_we     = 1'b0;
        im_waddr  = IA_W'(iaddr_reg);
        im_wdata  = iword_reg;
        dm_we     = 1'b0;
        dm_waddr  = DA_W'(maddr);
        dm_wdata  = r_reg;
        rf_we     = 1'b0;
        rf_waddr  = RA_W'(ir_reg.ra);
        rf_wdata  = res_reg;

        if (ctl.sweep_init || ctl.sweep_clear)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
            dm_waddr = DA_W'(cnt_reg);
            dm_wdata = (cnt_reg == '0) ? 32'(DMEM_DEPTH - 1) : 32'd0;
            dm_we    = (32'(cnt_reg) < 32'(DMEM_DEPTH));
        end
        if (ctl.sweep_init)
        begin
            im_waddr = IA_W'(cnt_reg);
            im_wdata = '0;
            im_we    = (32'(cnt_reg) < 32'(IMEM_DEPTH));
        end

        if (ctl.disp)
        begin
            st_next   = ST_OK;
            ov_next   = 1'b0;
            oval_next = 32'd0;
            case (cmd_reg)
                CMD_STEP:
                begin
                    if (stat.pc_fault)
                    begin
                        st_next = ST_IFAULT;
                    end
                    else
                    begin
                        pc_next = pc_reg + 32'd1;
                    end
                end
                CMD_WRITE:
                begin
                    im_we = (32'(iaddr_reg) < 32'(IMEM_DEPTH));
                end
                CMD_CLEAR:
                begin
                    vld_next = '0;
                    pc_next  = 32'd0;
                end
                default:
                begin
                    st_next = ST_OK;
                end
            endcase
        end

        if (ctl.exec)
        begin
            case (ir_reg.op)
                OP_HALT: st_next = ST_HALT;
                OP_IN:   res_next = inval_reg;
                OP_OUT:
                begin
                    ov_next   = 1'b1;
                    oval_next = r_reg;
                end
                OP_ADD:  res_next = s_reg + t_reg;
                OP_SUB:  res_next = s_reg - t_reg;
                OP_MUL:  res_next = s_reg * t_reg;
                OP_DIV:
                begin
                    if (dzero)
                    begin
                        st_next = ST_DIVZ;
                    end
                end
                OP_LD:
                begin
                    if (dfault)
                    begin
                        st_next = ST_DFAULT;
                    end
                end
                OP_ST:
                begin
                    if (dfault)
                    begin
                        st_next = ST_DFAULT;
                    end
                    else
                    begin
                        dm_we = 1'b1;
                    end
                end
                OP_LDA:  res_next = maddr;
                OP_LDC:  res_next = disp_ext;
                default:
                begin
                    if (take)
                    begin
                        pc_next = maddr;
                    end
                end
            endcase
        end

        if (ctl.div_cap)
        begin
            res_next = div_q;
        end
        if (ctl.ld_cap)
        begin
            res_next = dm_rdata;
        end

        // Write back: the pc index goes to the pc register.
        if (ctl.wb)
        begin
            if (32'(ir_reg.ra) == PC_INDEX)
            begin
                pc_next = res_reg;
            end
            else
            begin
                rf_we              = 1'b1;
                vld_next[rf_waddr] = 1'b1;
            end
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg  <= 32'd0;
            vld_reg <= '0;
            cnt_reg <= '0;
            rv_reg  <= 1'b0;
        end
        else
        begin
            pc_reg  <= pc_next;
            vld_reg <= vld_next;
            cnt_reg <= cnt_next;
            if (ctl.load_res)
            begin
                rv_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                rv_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (ctl.accept && in_valid)
        begin
            cmd_reg   <= cmd;
            iaddr_reg <= instr_addr;
            iword_reg <= '{op: instr_op, ra: instr_arg1, disp: instr_arg2, rb: instr_arg3};
            inval_reg <= in_value;
        end
        if (ctl.fetch)
        begin
            ir_reg <= im_rdata;
        end
        if (ctl.rd_t)
        begin
            t_reg <= rf_val;
        end
        if (ctl.rd_s)
        begin
            s_reg <= rf_val;
        end
        if (ctl.rd_r)
        begin
            r_reg <= rf_val;
        end
        rf_raddr_reg <= rf_raddr;
        res_reg      <= res_next;
        st_reg       <= st_next;
        ov_reg       <= ov_next;
        oval_reg     <= oval_next;
        if (ctl.load_res)
        begin
            ost_reg   <= st_reg;
            oov_reg   <= ov_reg;
            ooval_reg <= oval_reg;
            onpc_reg  <= pc_reg;
        end
    end

    // Status toward the controller.
    always_comb
    begin
        stat.cmd        = cmd_reg;
        stat.pc_fault   = (pc_reg >= 32'(IMEM_DEPTH));
        stat.op         = ir_reg.op;
        stat.div_zero   = dzero;
        stat.addr_fault = dfault;
        stat.div_done   = div_done;
        stat.init_last  = (cnt_reg == CNT_W'(MAX_DEPTH - 1));
        stat.clear_last = (32'(cnt_reg) == 32'(DMEM_DEPTH - 1));
        stat.out_free   = !rv_reg || res_ready;
    end

    assign res_valid = rv_reg;
    assign status    = ost_reg;
    assign out_valid = oov_reg;
    assign out_value = ooval_reg;
    assign next_pc   = onpc_reg;

endmodule

### rtl/core/tmcs_checker.sv
// ----------------------------------------------------------------------------
// tmcs_checker
// Port-level checks of the processor core, bound to the top level.
// ----------------------------------------------------------------------------
module tmcs_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               res_valid,
    input logic               res_ready,
    input logic [2:0]         status,
    input logic               out_valid,
    input logic signed [31:0] out_value,
    input logic signed [31:0] next_pc
);
    import tmcs_pkg::*;

    // A stalled result beat stays offered.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result beat dropped while stalled");

    // An OUT step always completes with status ok.
    a_out_ok: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && out_valid |-> status == ST_OK)
        else $error("OUT beat with non-ok status");

    // The printed value is zero unless the step was OUT.
    a_out_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !out_valid |-> out_value == 32'sd0)
        else $error("out_value set without OUT");

    // An instruction address fault leaves the pc outside the store.
    a_ifault: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && status == ST_IFAULT |-> unsigned'(next_pc) >= 32'(IMEM_DEPTH))
        else $error("instruction fault with pc in range");

endmodule

bind tiny_machine_cpu_step_top tmcs_checker u_tmcs_checker (.*);
